// File: design/nntt_pkg.sv
// shared constants and types for the nearest neighbor track table
package nntt_pkg;

	localparam int MAX_TRACKS = 32;
	localparam int SLOT_W     = $clog2(MAX_TRACKS);
	localparam int FRAC_BITS  = 4;

	// operand widths of the shared multiplier
	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 24;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// floor(v / 10) = (v * RECIP10) >> RECIP_SHIFT for v below 2^22
	localparam logic [MUL_B_W-1:0] RECIP10     = 24'd838861;
	localparam int                 RECIP_SHIFT = 23;

	// 3.6e6: meters per microsecond to km/h
	localparam logic [MUL_B_W-1:0] SPEED_SCALE = 24'd3600000;

	// input kinds
	localparam logic [1:0] KIND_FSTART = 2'd0;
	localparam logic [1:0] KIND_DET    = 2'd1;
	localparam logic [1:0] KIND_FEND   = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_UPDATED = 2'd0;
	localparam logic [1:0] STAT_CREATED = 2'd1;
	localparam logic [1:0] STAT_DROPPED = 2'd2;
	localparam logic [1:0] STAT_FRAME   = 2'd3;

	// configuration register indexes
	localparam logic [2:0] REG_ROI_TOP     = 3'd0;
	localparam logic [2:0] REG_SPEED_Y_MIN = 3'd1;
	localparam logic [2:0] REG_FRAME_ROWS  = 3'd2;
	localparam logic [2:0] REG_MPP         = 3'd3;
	localparam logic [2:0] REG_MAX_DIST    = 3'd4;
	localparam logic [2:0] REG_MAX_MISSED  = 3'd5;

	typedef logic [15:0]       q16_t;
	typedef logic [SLOT_W-1:0] slot_idx_t;

endpackage

// File: design/nearest_neighbor_track_table.sv
// nearest neighbor track table: sequencer around one shared multiplier
//
//  channel | signals                          | contents
//  --------+----------------------------------+-----------------------------------------
//  in      | s_tvalid s_tready s_tdata s_tuser| kind in tuser, timestamp and box in tdata
//  out     | m_tvalid m_tready m_tdata m_tuser| status in tuser, track state in tdata
//  cfg     | cfg_we cfg_addr cfg_wdata        | register writes, no read-back
//
// one request at a time; s_tready is high only while the sequencer is idle
// frame start and unknown kind: result in the cycle after the request; frame end: a sweep over all slots
// detection: a scan in three phases per slot, then a new track or a drop, or an update
//   without speed or with one (17 root steps, 12 divide steps)
// the result waits in the output register until m_tready; reset clears all slots at once
module nearest_neighbor_track_table (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [79:0]  s_tdata,   // timestamp_us[31:0], det_x[43:32], det_y[55:44],
	                                // det_w[67:56], det_h[79:68]
	input  logic [1:0]   s_tuser,   // kind[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,   // track_id[15:0], speed_kmh_q4[27:16], center_x_q4[43:28],
	                                // center_y_q4[59:44], width_q4[75:60], height_q4[91:76],
	                                // live_tracks[97:92], zero fill above
	output logic [1:0]   m_tuser,   // status[1:0]
	input  logic         cfg_we,
	input  logic [2:0]   cfg_addr,
	input  logic [15:0]  cfg_wdata
);

	localparam int F = nntt_pkg::FRAC_BITS;
	localparam int N = nntt_pkg::MAX_TRACKS;
	localparam int SW = nntt_pkg::SLOT_W;
	localparam int AW = nntt_pkg::MUL_A_W;
	localparam int BW = nntt_pkg::MUL_B_W;
	localparam int PW = nntt_pkg::PROD_W;
	localparam int RS = nntt_pkg::RECIP_SHIFT;

	// sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CENT  = 4'd1;
	localparam logic [3:0] S_GATE  = 4'd2;
	localparam logic [3:0] S_SCAN  = 4'd3;
	localparam logic [3:0] S_PICK  = 4'd4;
	localparam logic [3:0] S_EMA   = 4'd5;
	localparam logic [3:0] S_SPD   = 4'd6;
	localparam logic [3:0] S_SQ    = 4'd7;
	localparam logic [3:0] S_SUM   = 4'd8;
	localparam logic [3:0] S_SQRT  = 4'd9;
	localparam logic [3:0] S_NUM   = 4'd10;
	localparam logic [3:0] S_DIV   = 4'd11;
	localparam logic [3:0] S_SEMA  = 4'd12;
	localparam logic [3:0] S_WRITE = 4'd13;
	localparam logic [3:0] S_SWEEP = 4'd14;
	localparam logic [3:0] S_OUT   = 4'd15;

	localparam nntt_pkg::slot_idx_t LAST_SLOT = SW'(N - 1);

	// configuration
	logic [11:0] roi_top_q, speed_y_min_q, frame_rows_q, max_dist_q;
	logic [15:0] mpp_q;
	logic [3:0]  max_missed_q;

	// slot table
	logic [N-1:0]  valid_q;
	nntt_pkg::q16_t id_q     [N];
	nntt_pkg::q16_t pos_x_q  [N];
	nntt_pkg::q16_t pos_y_q  [N];
	nntt_pkg::q16_t width_q  [N];
	nntt_pkg::q16_t height_q [N];
	logic [31:0]   time_q   [N];
	logic [11:0]   speed_q  [N];
	logic [4:0]    missed_q [N];
	nntt_pkg::q16_t next_id_q;
	logic [31:0]   frame_time_q;
	logic [5:0]    live_q;

	// sequencer
	logic [3:0]  state_q;
	logic [1:0]  ph_q;
	logic [2:0]  k_q;
	logic [3:0]  cnt_q;
	nntt_pkg::slot_idx_t sel_q, bi_q, free_q;
	logic        found_q, free_found_q;

	// detection and working values
	logic [11:0] dx_q, dy_q, dw_q, dh_q;
	nntt_pkg::q16_t cx_q, cy_q, wq_q, hq_q;
	logic [33:0] best_q, sqx_q, rad_q, root_q, bit_q;
	nntt_pkg::q16_t best_id_q;
	nntt_pkg::q16_t ema_q [4];
	logic [31:0] dt_q;
	logic [59:0] rem_q, dv_q;
	logic [11:0] inst_q, spd_new_q;

	// shared multiplier
	logic [AW-1:0] mul_a;
	logic [BW-1:0] mul_b;
	logic [PW-1:0] prod_q;

	// output register
	logic [1:0]  o_status_q;
	nntt_pkg::q16_t o_id_q, o_cx_q, o_cy_q, o_w_q, o_h_q;
	logic [11:0] o_spd_q;

	// centre and size of the detection, saturated to 16 bits
	logic [23:0] cx_sum, cy_sum, cx_full, cy_full, wq_full, hq_full;
	nntt_pkg::q16_t cx_c, cy_c, wq_c, hq_c;
	logic [23:0] gate_c;

	always_comb begin
		cx_sum  = {11'd0, dx_q, 1'b0} + {12'd0, dw_q};
		cy_sum  = {10'd0, ({1'b0, dy_q} + {1'b0, roi_top_q}), 1'b0} + {12'd0, dh_q};
		cx_full = (cx_sum << F) >> 1;
		cy_full = (cy_sum << F) >> 1;
		wq_full = {12'd0, dw_q} << F;
		hq_full = {12'd0, dh_q} << F;
		cx_c    = (|cx_full[23:16]) ? 16'hFFFF : cx_full[15:0];
		cy_c    = (|cy_full[23:16]) ? 16'hFFFF : cy_full[15:0];
		wq_c    = (|wq_full[23:16]) ? 16'hFFFF : wq_full[15:0];
		hq_c    = (|hq_full[23:16]) ? 16'hFFFF : hq_full[15:0];
		gate_c  = {12'd0, max_dist_q} << F;
	end

	// current slot fields
	logic           cur_valid;
	nntt_pkg::q16_t cur_id, cur_x, cur_y;
	logic [11:0]    cur_spd;
	logic [31:0]    cur_time;
	nntt_pkg::q16_t ex, ey, mx, my;
	logic [33:0]    d2;
	logic           better;

	always_comb begin
		cur_valid = valid_q[sel_q];
		cur_id    = id_q[sel_q];
		cur_x     = pos_x_q[sel_q];
		cur_y     = pos_y_q[sel_q];
		cur_spd   = speed_q[sel_q];
		cur_time  = time_q[sel_q];
		ex = (cx_q > cur_x) ? cx_q - cur_x : cur_x - cx_q;
		ey = (cy_q > cur_y) ? cy_q - cur_y : cur_y - cy_q;
		mx = (ema_q[0] > cur_x) ? ema_q[0] - cur_x : cur_x - ema_q[0];
		my = (ema_q[1] > cur_y) ? ema_q[1] - cur_y : cur_y - ema_q[1];
		d2 = sqx_q + prod_q[33:0];
		// ties go to the lower track id
		better = cur_valid && ((d2 < best_q) ||
		         (found_q && (d2 == best_q) && (cur_id < best_id_q)));
	end

	// smoothing numerators: 7*old + 3*target + 5
	nntt_pkg::q16_t ema_old, ema_tgt;
	logic [19:0]    ema_num;
	logic [15:0]    sema_num;

	always_comb begin
		case (k_q[1:0])
			2'd0: begin ema_old = cur_x; ema_tgt = cx_q; end
			2'd1: begin ema_old = cur_y; ema_tgt = cy_q; end
			2'd2: begin ema_old = width_q[sel_q]; ema_tgt = wq_q; end
			default: begin ema_old = height_q[sel_q]; ema_tgt = hq_q; end
		endcase
		ema_num  = ({4'd0, ema_old} << 3) - {4'd0, ema_old} + ({4'd0, ema_tgt} << 1)
		           + {4'd0, ema_tgt} + 20'd5;
		// 2*inst + 8*old + 5
		sema_num = ({4'd0, inst_q} << 1) + ({4'd0, cur_spd} << 3) + 16'd5;
	end

	// speed update gate
	logic        spd_ok;
	logic [19:0] ny_w, ymin_w, yrows_w;

	always_comb begin
		ny_w    = {4'd0, ema_q[1]};
		ymin_w  = {8'd0, speed_y_min_q} << F;
		yrows_w = {8'd0, frame_rows_q} << F;
		spd_ok  = (cur_time != 32'd0) && (frame_time_q > cur_time) &&
		          (ny_w > ymin_w) && (ny_w < yrows_w);
	end

	// square root step
	logic [33:0] sq_trial;
	logic        sq_ge;
	// restoring divide step
	logic        div_ge;
	logic [59:0] sat_lim;

	always_comb begin
		sq_trial = root_q + bit_q;
		sq_ge    = rad_q >= sq_trial;
		div_ge   = rem_q >= dv_q;
		sat_lim  = {dt_q, 28'd0};
	end

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_CENT: begin
				mul_a = AW'(gate_c);
				mul_b = BW'(gate_c);
			end
			S_SCAN: begin
				if (ph_q == 2'd0) begin
					mul_a = AW'(ex);
					mul_b = BW'(ex);
				end else begin
					mul_a = AW'(ey);
					mul_b = BW'(ey);
				end
			end
			S_EMA: begin
				mul_a = AW'(ema_num);
				mul_b = nntt_pkg::RECIP10;
			end
			S_SPD: begin
				mul_a = AW'(mx);
				mul_b = BW'(mx);
			end
			S_SQ: begin
				mul_a = AW'(my);
				mul_b = BW'(my);
			end
			S_NUM: begin
				if (ph_q == 2'd0) begin
					mul_a = AW'(root_q[16:0]);
					mul_b = BW'(mpp_q);
				end else begin
					mul_a = prod_q[AW-1:0];
					mul_b = nntt_pkg::SPEED_SCALE;
				end
			end
			S_SEMA: begin
				mul_a = AW'(sema_num);
				mul_b = nntt_pkg::RECIP10;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			ph_q          <= '0;
			k_q           <= '0;
			cnt_q         <= '0;
			sel_q         <= '0;
			found_q       <= 1'b0;
			free_found_q  <= 1'b0;
			valid_q       <= '0;
			live_q        <= '0;
			next_id_q     <= 16'd1;
			frame_time_q  <= '0;
			roi_top_q     <= 12'd216;
			speed_y_min_q <= 12'd288;
			frame_rows_q  <= 12'd480;
			mpp_q         <= 16'd933;
			max_dist_q    <= 12'd80;
			max_missed_q  <= 4'd10;
		end else begin
			prod_q <= mul_a * mul_b;

			if (cfg_we) begin
				case (cfg_addr)
					nntt_pkg::REG_ROI_TOP:     roi_top_q     <= cfg_wdata[11:0];
					nntt_pkg::REG_SPEED_Y_MIN: speed_y_min_q <= cfg_wdata[11:0];
					nntt_pkg::REG_FRAME_ROWS:  frame_rows_q  <= cfg_wdata[11:0];
					nntt_pkg::REG_MPP:         mpp_q         <= cfg_wdata;
					nntt_pkg::REG_MAX_DIST:    max_dist_q    <= cfg_wdata[11:0];
					nntt_pkg::REG_MAX_MISSED:  max_missed_q  <= cfg_wdata[3:0];
					default: ;
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						// frame items answer with everything but status and count zeroed
						o_status_q <= nntt_pkg::STAT_FRAME;
						o_id_q     <= '0;
						o_spd_q    <= '0;
						o_cx_q     <= '0;
						o_cy_q     <= '0;
						o_w_q      <= '0;
						o_h_q      <= '0;
						case (s_tuser)
							nntt_pkg::KIND_FSTART: begin
								frame_time_q <= s_tdata[31:0];
								for (int i = 0; i < N; i++) begin
									if (valid_q[i] && missed_q[i] != 5'd31)
										missed_q[i] <= missed_q[i] + 5'd1;
								end
								state_q <= S_OUT;
							end
							nntt_pkg::KIND_DET: begin
								dx_q    <= s_tdata[43:32];
								dy_q    <= s_tdata[55:44];
								dw_q    <= s_tdata[67:56];
								dh_q    <= s_tdata[79:68];
								state_q <= S_CENT;
							end
							nntt_pkg::KIND_FEND: begin
								sel_q   <= '0;
								state_q <= S_SWEEP;
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_CENT: begin
					// gate squared goes through the multiplier here
					cx_q    <= cx_c;
					cy_q    <= cy_c;
					wq_q    <= wq_c;
					hq_q    <= hq_c;
					state_q <= S_GATE;
				end
				S_GATE: begin
					best_q       <= prod_q[33:0];
					found_q      <= 1'b0;
					free_found_q <= 1'b0;
					sel_q        <= '0;
					ph_q         <= '0;
					state_q      <= S_SCAN;
				end
				S_SCAN: begin
					// three phases per slot: ex^2, ey^2, sum and compare
					case (ph_q)
						2'd0: ph_q <= 2'd1;
						2'd1: begin
							sqx_q <= prod_q[33:0];
							ph_q  <= 2'd2;
						end
						default: begin
							if (better) begin
								best_q    <= d2;
								bi_q      <= sel_q;
								best_id_q <= cur_id;
								found_q   <= 1'b1;
							end
							if (!cur_valid && !free_found_q) begin
								free_q       <= sel_q;
								free_found_q <= 1'b1;
							end
							ph_q <= 2'd0;
							if (sel_q == LAST_SLOT)
								state_q <= S_PICK;
							else
								sel_q <= sel_q + 1'b1;
						end
					endcase
				end
				S_PICK: begin
					if (found_q) begin
						sel_q   <= bi_q;
						k_q     <= '0;
						state_q <= S_EMA;
					end else if (free_found_q) begin
						// new track in the lowest free slot
						valid_q[free_q]  <= 1'b1;
						id_q[free_q]     <= next_id_q;
						pos_x_q[free_q]  <= cx_q;
						pos_y_q[free_q]  <= cy_q;
						width_q[free_q]  <= wq_q;
						height_q[free_q] <= hq_q;
						time_q[free_q]   <= frame_time_q;
						speed_q[free_q]  <= '0;
						missed_q[free_q] <= '0;
						// id wraps past zero
						next_id_q  <= (next_id_q == 16'hFFFF) ? 16'd1 : next_id_q + 16'd1;
						live_q     <= live_q + 6'd1;
						o_status_q <= nntt_pkg::STAT_CREATED;
						o_id_q     <= next_id_q;
						o_spd_q    <= '0;
						o_cx_q     <= cx_q;
						o_cy_q     <= cy_q;
						o_w_q      <= wq_q;
						o_h_q      <= hq_q;
						state_q    <= S_OUT;
					end else begin
						// table full: report the detection itself
						o_status_q <= nntt_pkg::STAT_DROPPED;
						o_cx_q     <= cx_q;
						o_cy_q     <= cy_q;
						o_w_q      <= wq_q;
						o_h_q      <= hq_q;
						state_q    <= S_OUT;
					end
				end
				S_EMA: begin
					// x, y, w, h issued one per cycle, each captured from the product register in the cycle after
					if (k_q != 3'd0)
						ema_q[2'(k_q - 3'd1)] <= prod_q[RS+15:RS];
					if (k_q == 3'd4)
						state_q <= S_SPD;
					else
						k_q <= k_q + 3'd1;
				end
				S_SPD: begin
					spd_new_q <= cur_spd;
					dt_q      <= frame_time_q - cur_time;
					state_q   <= spd_ok ? S_SQ : S_WRITE;
				end
				S_SQ: begin
					sqx_q   <= prod_q[33:0];
					state_q <= S_SUM;
				end
				S_SUM: begin
					rad_q   <= sqx_q + prod_q[33:0];
					root_q  <= '0;
					bit_q   <= 34'h1_0000_0000;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					if (sq_ge) begin
						rad_q  <= rad_q - sq_trial;
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						ph_q    <= '0;
						state_q <= S_NUM;
					end
				end
				S_NUM: begin
					// dist * scale, then * 3.6e6, then add half the divisor for rounding
					case (ph_q)
						2'd0: ph_q <= 2'd1;
						2'd1: ph_q <= 2'd2;
						2'd2: begin
							rem_q <= {5'd0, prod_q[54:0]} + {13'd0, dt_q, 15'd0};
							ph_q  <= 2'd3;
						end
						default: begin
							ph_q <= '0;
							if (rem_q >= sat_lim) begin
								inst_q  <= 12'd4095;
								state_q <= S_SEMA;
							end else begin
								inst_q  <= '0;
								dv_q    <= {1'b0, dt_q, 27'd0};
								cnt_q   <= '0;
								state_q <= S_DIV;
							end
						end
					endcase
				end
				S_DIV: begin
					if (div_ge)
						rem_q <= rem_q - dv_q;
					inst_q <= {inst_q[10:0], div_ge};
					dv_q   <= dv_q >> 1;
					cnt_q  <= cnt_q + 4'd1;
					if (cnt_q == 4'd11) begin
						ph_q    <= '0;
						state_q <= S_SEMA;
					end
				end
				S_SEMA: begin
					if (ph_q == 2'd0) begin
						// a zero speed is seeded with the first value
						if (cur_spd == 12'd0) begin
							spd_new_q <= inst_q;
							state_q   <= S_WRITE;
						end else begin
							ph_q <= 2'd1;
						end
					end else begin
						spd_new_q <= prod_q[RS+11:RS];
						ph_q      <= '0;
						state_q   <= S_WRITE;
					end
				end
				S_WRITE: begin
					pos_x_q[sel_q]  <= ema_q[0];
					pos_y_q[sel_q]  <= ema_q[1];
					width_q[sel_q]  <= ema_q[2];
					height_q[sel_q] <= ema_q[3];
					time_q[sel_q]   <= frame_time_q;
					speed_q[sel_q]  <= spd_new_q;
					missed_q[sel_q] <= '0;
					o_status_q      <= nntt_pkg::STAT_UPDATED;
					o_id_q          <= cur_id;
					o_spd_q         <= spd_new_q;
					o_cx_q          <= ema_q[0];
					o_cy_q          <= ema_q[1];
					o_w_q           <= ema_q[2];
					o_h_q           <= ema_q[3];
					state_q         <= S_OUT;
				end
				S_SWEEP: begin
					// drop stale tracks, one slot per cycle
					if (cur_valid && (missed_q[sel_q] > {1'b0, max_missed_q})) begin
						valid_q[sel_q] <= 1'b0;
						live_q         <= live_q - 6'd1;
					end
					if (sel_q == LAST_SLOT)
						state_q <= S_OUT;
					else
						sel_q <= sel_q + 1'b1;
				end
				S_OUT: begin
					if (m_tready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign m_tuser  = o_status_q;
	assign m_tdata  = {6'd0, live_q, o_h_q, o_w_q, o_cy_q, o_cx_q, o_spd_q, o_id_q};

endmodule
